// ===== rtl/max_priority_queue_unit_assert.svh =====
`ifndef MAX_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max_priority_queue_unit: check failed");

// Next-cycle implication, disabled while reset is high.
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max_priority_queue_unit: check failed");

`endif

// ===== rtl/mpq_pkg.sv =====
package mpq_pkg;

  localparam int VALUE_W = 32;
  localparam int FILL_W = 5;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [FILL_W-1:0]          fill_count;
  } out_word_t;

  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== rtl/max_priority_queue_unit.sv =====
// Bounded max-priority queue of signed 32-bit values. A command is taken when
// start is high and busy is low; busy is then raised, and the result word
// appears on result with done high for exactly one cycle after that. No new
// command is taken while busy is high. The receiver cannot stall: done is a
// one-cycle strobe and the word must be captured when it is shown. The values
// live in a row of DEPTH cells kept sorted largest first; an insert moves the
// cells from the new value's place on down by one cell and a removal moves the
// whole row up by one, in a single pass, every cell comparing the new value
// with its own and looking at its neighbors. Write cfg_wr_en and cfg_wr_data
// only while no command is in flight; a capacity above DEPTH acts as DEPTH.
module max_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_word_t         request,
  output logic             done,
  output out_word_t        result,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [CAP_W-1:0]          capacity;
  in_word_t                  req;
  out_word_t                 result_next;
  cell_ctl_t                 ctl;
  logic                      full;
  logic                      empty;
  logic signed [VALUE_W-1:0] cell_data [DEPTH];
  logic                      cell_gt [DEPTH];

  assign full  = (MW'(count) >= MW'(capacity)) || (count >= CW'(DEPTH));
  assign empty = count == '0;

  always_comb begin
    ctl.ins   = busy && (req.command == CMD_INSERT) && !full;
    ctl.rem   = busy && (req.command == CMD_REMOVE) && !empty;
    ctl.value = req.value;

    count_next                = count;
    result_next.status        = ST_OK;
    result_next.removed_value = '0;
    if (req.command == CMD_INSERT) begin
      if (full) begin
        result_next.status = ST_OVERFLOW;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        result_next.status = ST_UNDERFLOW;
      end else begin
        result_next.removed_value = cell_data[0];
        count_next = count - 1'b1;
      end
    end
    result_next.fill_count = FILL_W'(count_next);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_data;
    logic                      prev_gt;
    logic signed [VALUE_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = cell_data[0];
      assign prev_gt   = 1'b0;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
      assign prev_gt   = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    mpq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .prev_data (prev_data),
      .prev_gt   (prev_gt),
      .next_data (next_data),
      .data      (cell_data[i]),
      .gt        (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      done <= busy;
      busy <= start && !busy;
      if (busy) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
    if (busy) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/mpq_cell.sv =====
module mpq_cell
  import mpq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic [CW-1:0]             count,
  input  logic signed [VALUE_W-1:0] prev_data,
  input  logic                      prev_gt,
  input  logic signed [VALUE_W-1:0] next_data,
  output logic signed [VALUE_W-1:0] data,
  output logic                      gt
);

  logic occupied;

  // The row is kept sorted largest first; an empty cell ranks below any value.
  assign occupied = count > CW'(IDX);
  assign gt = !occupied || (ctl.value > data);

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      data <= prev_gt ? prev_data : ctl.value;
    end else if (ctl.rem) begin
      data <= next_data;
    end
  end

endmodule

// ===== rtl/mpq_checker.sv =====
`include "max_priority_queue_unit_assert.svh"

module mpq_checker
  import mpq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_word_t result
);

  logic status_legal;
  logic underflow_word;
  logic underflow_clean;
  logic overflow_word;

  assign status_legal    = (result.status == ST_OK) || (result.status == ST_OVERFLOW) ||
                           (result.status == ST_UNDERFLOW);
  assign underflow_word  = done && (result.status == ST_UNDERFLOW);
  assign underflow_clean = (result.fill_count == '0) && (result.removed_value == '0);
  assign overflow_word   = done && (result.status == ST_OVERFLOW);

  `MPQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `MPQ_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  `MPQ_ASSERT_NOW(a_status_code, clk, rst, done, status_legal)
  `MPQ_ASSERT_NOW(a_underflow_empty, clk, rst, underflow_word, underflow_clean)
  `MPQ_ASSERT_NOW(a_overflow_zero, clk, rst, overflow_word, result.removed_value == '0)

endmodule

bind max_priority_queue_unit mpq_checker u_mpq_checker (.*);
